>>> design/sbi_pkg.sv
// shared constants and types for the segment versus box intersection pipeline
// no dependencies
package sbi_pkg;

    localparam int NAXIS = 3;
    localparam int CW    = 32;       // coordinate width
    localparam int DW    = CW + 1;   // difference width
    localparam int PW    = 2 * DW;   // product width

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [DW-1:0] t_diff;
    typedef logic        [DW-1:0] t_mag;
    typedef logic        [PW-1:0] t_prod;

    // stage advance controls handed to each axis slice
    typedef struct packed {
        logic en1;
        logic en2;
    } t_adv;

endpackage

>>> design/sbi_axis.sv
// one axis slice: slab differences, then direction fold and clamp to [0,1]
// depends on sbi_pkg
module sbi_axis (
    input  logic           i_clk,
    input  sbi_pkg::t_adv  i_adv,
    input  sbi_pkg::t_coord i_s,
    input  sbi_pkg::t_coord i_e,
    input  sbi_pkg::t_coord i_lo,
    input  sbi_pkg::t_coord i_hi,
    output sbi_pkg::t_mag  o_a,
    output sbi_pkg::t_mag  o_b,
    output sbi_pkg::t_mag  o_d,
    output logic           o_active,
    output logic           o_miss
);
    import sbi_pkg::*;

    t_diff r_d, r_n0, r_n1;
    t_mag  r_a, r_b, r_dm;
    logic  r_active, r_miss;

    logic signed [DW:0] w_m0, w_m1, w_lo, w_hi;
    t_mag  w_dm;
    logic  w_neg, w_zero, w_miss;
    t_mag  w_a, w_b;

    always_ff @(posedge i_clk) begin
        if (i_adv.en1) begin
            r_d  <= $signed({i_e[CW-1], i_e})  - $signed({i_s[CW-1], i_s});
            r_n0 <= $signed({i_lo[CW-1], i_lo}) - $signed({i_s[CW-1], i_s});
            r_n1 <= $signed({i_hi[CW-1], i_hi}) - $signed({i_s[CW-1], i_s});
        end
    end

    always_comb begin
        w_neg  = r_d[DW-1];
        w_zero = (r_d == '0);
        w_dm   = w_neg ? t_mag'(-r_d) : t_mag'(r_d);
        w_m0   = w_neg ? -$signed({r_n0[DW-1], r_n0}) : $signed({r_n0[DW-1], r_n0});
        w_m1   = w_neg ? -$signed({r_n1[DW-1], r_n1}) : $signed({r_n1[DW-1], r_n1});
        // order the two crossing times
        w_lo   = (w_m0 > w_m1) ? w_m1 : w_m0;
        w_hi   = (w_m0 > w_m1) ? w_m0 : w_m1;
        if (w_zero) begin
            // start must sit inside the slab
            w_miss = (r_n0 > 0) || (r_n1 < 0);
        end else begin
            w_miss = (w_hi < 0) || (w_lo > $signed({1'b0, w_dm}));
        end
        w_a = (w_lo > 0) ? w_lo[DW-1:0] : '0;
        w_b = (w_hi < $signed({1'b0, w_dm})) ? w_hi[DW-1:0] : w_dm;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.en2) begin
            r_a      <= w_a;
            r_b      <= w_b;
            r_dm     <= w_dm;
            r_active <= !w_zero;
            r_miss   <= w_miss;
        end
    end

    assign o_a      = r_a;
    assign o_b      = r_b;
    assign o_d      = r_dm;
    assign o_active = r_active;
    assign o_miss   = r_miss;

endmodule

>>> design/segment_box_intersect.sv
// top level of the segment versus box slab test
// depends on sbi_pkg and sbi_axis
// Takes one request per cycle while o_stall is low and returns one hit flag per
// request, in order, through registered stages: differences, direction fold and
// clamp, cross products of entry and exit times across axes, then the compare
// into the output register. Each stage advances on its own, so bubbles close up
// while the output is stalled.
module segment_box_intersect (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_start_z,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_end_z,
    input  logic signed [31:0] i_box_min_x,
    input  logic signed [31:0] i_box_min_y,
    input  logic signed [31:0] i_box_min_z,
    input  logic signed [31:0] i_box_max_x,
    input  logic signed [31:0] i_box_max_y,
    input  logic signed [31:0] i_box_max_z,
    output logic o_valid,
    input  logic i_stall,
    output logic o_hits
);
    import sbi_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;
    t_adv adv;

    t_coord s [NAXIS];
    t_coord e [NAXIS];
    t_coord lo [NAXIS];
    t_coord hi [NAXIS];
    t_mag   a [NAXIS];
    t_mag   b [NAXIS];
    t_mag   d [NAXIS];
    logic   act [NAXIS];
    logic   miss [NAXIS];

    // products for every ordered pair of axes: entry(i)*d(j) vs exit(j)*d(i)
    t_prod r_p [NAXIS][NAXIS];
    t_prod r_q [NAXIS][NAXIS];
    logic [NAXIS-1:0] r_act3;
    logic  r_miss3;
    logic  r_hits;
    logic  w_hits;

    assign en4 = !r_v4 || !i_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign adv.en1 = en1;
    assign adv.en2 = en2;
    assign o_stall = !en1;

    assign s  = '{i_start_x, i_start_y, i_start_z};
    assign e  = '{i_end_x, i_end_y, i_end_z};
    assign lo = '{i_box_min_x, i_box_min_y, i_box_min_z};
    assign hi = '{i_box_max_x, i_box_max_y, i_box_max_z};

    for (genvar k = 0; k < NAXIS; k++) begin : g_axis
        sbi_axis u_axis (
            .i_clk    (i_clk),
            .i_adv    (adv),
            .i_s      (s[k]),
            .i_e      (e[k]),
            .i_lo     (lo[k]),
            .i_hi     (hi[k]),
            .o_a      (a[k]),
            .o_b      (b[k]),
            .o_d      (d[k]),
            .o_active (act[k]),
            .o_miss   (miss[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            for (int i = 0; i < NAXIS; i++) begin
                for (int j = 0; j < NAXIS; j++) begin
                    r_p[i][j] <= a[i] * d[j];
                    r_q[i][j] <= b[j] * d[i];
                end
                r_act3[i] <= act[i];
            end
            r_miss3 <= miss[0] || miss[1] || miss[2];
        end
    end

    always_comb begin
        w_hits = !r_miss3;
        for (int i = 0; i < NAXIS; i++) begin
            for (int j = 0; j < NAXIS; j++) begin
                // entry on axis i later than exit on axis j empties the interval
                if (i != j && r_act3[i] && r_act3[j] && (r_p[i][j] > r_q[i][j])) begin
                    w_hits = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_hits <= w_hits;
        end
    end

    assign o_valid = r_v4;
    assign o_hits  = r_hits;

endmodule

>>> design/sbi_checker.sv
// port level checks for segment_box_intersect, attached by bind
// depends on segment_box_intersect ports only
module sbi_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_hits
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hits))
        else $error("stalled result changed");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("request stalled while output free");

endmodule

bind segment_box_intersect sbi_checker u_sbi_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_hits  (o_hits)
);
